// File: hdl/lane_edge_tracker_steering_macros.svh
// ----------------------------------------------------------------------------
// Lane edge tracker assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LANE_EDGE_TRACKER_STEERING_MACROS_SVH
`define LANE_EDGE_TRACKER_STEERING_MACROS_SVH

// same-cycle implication
`define LETS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LETS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lets_pkg.sv
// ----------------------------------------------------------------------------
// Lane edge tracker package
// Shared constants, register indexes and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lets_pkg;

  localparam int SCAN_ROWS = 40;
  localparam int IMG_COLS  = 80;
  localparam int IMG_ROWS  = 60;
  localparam int HALF_COLS = 40;

  localparam int ROW_AW = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
  localparam int RC_W   = 6;

  localparam int LEFT_W   = 6;
  localparam int RIGHT_W  = 7;
  localparam int CENTER_W = 8;
  localparam int CROSS_W  = 6;
  localparam int DUTY_W   = 14;
  localparam int GAIN_W   = 8;
  localparam int GSUM_W   = 9;
  localparam int CFG_IW   = 3;

  localparam int SCAN_ORIGIN = 40;
  localparam int LEFT_N      = 39;
  localparam int RIGHT_N     = 38;
  localparam int LEFT_DEF    = 1;
  localparam int RIGHT_DEF   = 78;
  localparam int CENTER_DEF  = 40;
  localparam int CROSS_GAP   = 60;
  localparam int TURN_BONUS  = 20;

  localparam int ROW_A  = 39;
  localparam int ROW_B  = 30;
  localparam int RC_A   = IMG_ROWS - 1 - ROW_A;
  localparam int RC_B   = IMG_ROWS - 1 - ROW_B;

  localparam int RECIP_10 = 6554;
  localparam int RECIP_SH = 16;

  localparam logic [CFG_IW-1:0] REG_DUTY_CENTER = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DUTY_GAIN   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DUTY_MIN    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_DUTY_MAX    = 3'd3;

  typedef struct packed {
    logic                lf;
    logic [LEFT_W-1:0]   left;
    logic                rf;
    logic [RIGHT_W-1:0]  right;
  } edge_t;

  typedef struct packed {
    logic                last;
    logic [CENTER_W-1:0] ca;
    logic [CENTER_W-1:0] cb;
    logic [GSUM_W-1:0]   gain;
  } steer_t;

  typedef struct packed {
    logic [DUTY_W-1:0] center;
    logic [DUTY_W-1:0] dmin;
    logic [DUTY_W-1:0] dmax;
  } duty_cfg_t;

endpackage

`default_nettype wire

// File: hdl/lets_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lets_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/lets_edge_scan.sv
// ----------------------------------------------------------------------------
// Lane edge scan
// One detector lane per candidate column on each side, merged by a
// nearest-to-center priority select.
// ----------------------------------------------------------------------------
`default_nettype none

module lets_edge_scan (
  input  logic [lets_pkg::HALF_COLS-1:0] pixels_low,
  input  logic [lets_pkg::HALF_COLS-1:0] pixels_high,
  output lets_pkg::edge_t                edge_o
);

  logic [lets_pkg::IMG_COLS-1:0] pix;
  logic [lets_pkg::LEFT_N-1:0]   hit_l;
  logic [lets_pkg::RIGHT_N-1:0]  hit_r;

  assign pix = {pixels_high, pixels_low};

  always_comb begin
    for (int k = 0; k < lets_pkg::LEFT_N; k++) begin
      hit_l[k] = pix[lets_pkg::SCAN_ORIGIN - k] & ~pix[lets_pkg::SCAN_ORIGIN - 2 - k];
    end
    for (int k = 0; k < lets_pkg::RIGHT_N; k++) begin
      hit_r[k] = pix[lets_pkg::SCAN_ORIGIN + k] & ~pix[lets_pkg::SCAN_ORIGIN + 2 + k];
    end
  end

  always_comb begin
    edge_o.lf    = |hit_l;
    edge_o.left  = lets_pkg::LEFT_W'(lets_pkg::LEFT_DEF);
    for (int k = lets_pkg::LEFT_N - 1; k >= 0; k--) begin
      if (hit_l[k]) begin
        edge_o.left = lets_pkg::LEFT_W'(lets_pkg::SCAN_ORIGIN + 2 - k);
      end
    end
    edge_o.rf    = |hit_r;
    edge_o.right = lets_pkg::RIGHT_W'(lets_pkg::RIGHT_DEF);
    for (int k = lets_pkg::RIGHT_N - 1; k >= 0; k--) begin
      if (hit_r[k]) begin
        edge_o.right = lets_pkg::RIGHT_W'(lets_pkg::SCAN_ORIGIN - 2 + k);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/lets_steer.sv
// ----------------------------------------------------------------------------
// Steering duty pipeline
// Weighted center error, divide by ten, gain multiply and duty clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module lets_steer (
  input  logic                        clk,
  input  logic                        advance,
  input  lets_pkg::steer_t            st,
  input  lets_pkg::duty_cfg_t         cfg,
  output logic [lets_pkg::DUTY_W-1:0] duty
);

  logic signed [9:0]  ea, eb;
  logic signed [12:0] wsum;
  logic [11:0]        mag;
  logic [24:0]        prod;
  logic [7:0]         quo;
  logic signed [8:0]  t_nxt;

  logic signed [8:0]              t_r;
  logic [lets_pkg::GSUM_W-1:0]    g_r;
  logic                           last_r;

  logic signed [18:0] pg;
  logic signed [19:0] d0, d1, d2;
  logic signed [19:0] smin, smax;

  always_comb begin
    ea    = $signed({2'b00, st.ca}) - 10'sd40;
    eb    = $signed({2'b00, st.cb}) - 10'sd40;
    wsum  = 13'(ea * 8) + 13'(eb * 2);
    mag   = wsum[12] ? 12'(-wsum) : 12'(wsum);
    prod  = 25'(mag) * 25'(lets_pkg::RECIP_10);
    quo   = prod[lets_pkg::RECIP_SH +: 8];
    t_nxt = wsum[12] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t_r    <= t_nxt;
      g_r    <= st.gain;
      last_r <= st.last;
    end
  end

  always_comb begin
    pg   = t_r * $signed({1'b0, g_r});
    smin = $signed({6'b0, cfg.dmin});
    smax = $signed({6'b0, cfg.dmax});
    d0   = $signed({6'b0, cfg.center}) + 20'(pg);
    d1   = (d0 <= smin) ? smin : d0;
    d2   = (d1 >= smax) ? smax : d1;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      duty <= last_r ? d2[lets_pkg::DUTY_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lane_edge_tracker_steering.sv
// Pipeline: a row passes through the s1, s2 and output registers before it reaches the output.
// Throughput: one row per cycle while out_ready is high; a stall holds all stages.
// Rate set by the combinational edge lanes and the two-stage duty pipeline.
// Reset: synchronous rst_n clears row state and valid flags and sets duty registers to defaults.
// The center store is cleared at once by per-row valid bits.
// ----------------------------------------------------------------------------
// Lane edge tracker with steering output
// Finds lane edges per row, tracks row centers and computes steering duty.
// ----------------------------------------------------------------------------
`default_nettype none

module lane_edge_tracker_steering (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lets_pkg::HALF_COLS-1:0]  in_pixels_low,
  input  logic [lets_pkg::HALF_COLS-1:0]  in_pixels_high,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lets_pkg::LEFT_W-1:0]     out_left_edge,
  output logic [lets_pkg::RIGHT_W-1:0]    out_right_edge,
  output logic [lets_pkg::CENTER_W-1:0]   out_center_col,
  output logic                            out_frame_done,
  output logic [lets_pkg::DUTY_W-1:0]     out_steer_duty,
  input  logic                            cfg_we,
  input  logic [lets_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [lets_pkg::DUTY_W-1:0]     cfg_wdata
);

`include "lane_edge_tracker_steering_macros.svh"

  logic [lets_pkg::DUTY_W-1:0] duty_center_r, duty_min_r, duty_max_r;
  logic [lets_pkg::GAIN_W-1:0] duty_gain_r;

  logic [lets_pkg::RC_W-1:0]     rc_r, rc_nxt;
  logic [lets_pkg::RIGHT_W-1:0]  prev_left_r, prev_right_r;
  logic [lets_pkg::CENTER_W-1:0] prev_center_r;
  logic [lets_pkg::CROSS_W-1:0]  cross_r, cross_nxt;
  logic                          lturn_r, lturn_nxt, rturn_r, rturn_nxt;
  logic [lets_pkg::SCAN_ROWS-1:0] row_valid_r;
  logic [lets_pkg::CENTER_W-1:0] ca_r, cb_r;

  logic                          advance, accept, last, gap;
  lets_pkg::edge_t               edg;
  logic [lets_pkg::CENTER_W-1:0] ram_rdata, stored, c;
  logic [lets_pkg::ROW_AW-1:0]   ram_raddr;
  lets_pkg::steer_t              st_nxt;
  lets_pkg::duty_cfg_t           dcfg;

  logic                          s1_valid_r, s2_valid_r, out_valid_r;
  logic [lets_pkg::LEFT_W-1:0]   s1_left_r, s2_left_r;
  logic [lets_pkg::RIGHT_W-1:0]  s1_right_r, s2_right_r;
  logic [lets_pkg::CENTER_W-1:0] s1_c_r, s2_c_r;
  logic                          s2_last_r;
  lets_pkg::steer_t              s1_st_r;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_center_r <= lets_pkg::DUTY_W'(5000);
      duty_gain_r   <= lets_pkg::GAIN_W'(10);
      duty_min_r    <= lets_pkg::DUTY_W'(4000);
      duty_max_r    <= lets_pkg::DUTY_W'(6000);
    end else if (cfg_we) begin
      case (cfg_index)
        lets_pkg::REG_DUTY_CENTER: duty_center_r <= cfg_wdata;
        lets_pkg::REG_DUTY_GAIN:   duty_gain_r   <= cfg_wdata[lets_pkg::GAIN_W-1:0];
        lets_pkg::REG_DUTY_MIN:    duty_min_r    <= cfg_wdata;
        lets_pkg::REG_DUTY_MAX:    duty_max_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lets_edge_scan u_scan (
    .pixels_low  (in_pixels_low),
    .pixels_high (in_pixels_high),
    .edge_o      (edg)
  );

  assign last      = (rc_r == lets_pkg::RC_W'(lets_pkg::SCAN_ROWS - 1));
  assign rc_nxt    = last ? '0 : rc_r + 1'b1;
  assign ram_raddr = accept ? rc_nxt[lets_pkg::ROW_AW-1:0] : rc_r[lets_pkg::ROW_AW-1:0];

  lets_ram #(
    .WIDTH (lets_pkg::CENTER_W),
    .DEPTH (lets_pkg::SCAN_ROWS)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (rc_r[lets_pkg::ROW_AW-1:0]),
    .wdata (c),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    stored    = row_valid_r[rc_r[lets_pkg::ROW_AW-1:0]] ? ram_rdata : '0;
    gap       = {1'b0, edg.right} > ({2'b00, edg.left} + 8'(lets_pkg::CROSS_GAP));
    c         = stored;
    cross_nxt = cross_r;
    lturn_nxt = lturn_r;
    rturn_nxt = rturn_r;
    if (edg.lf && edg.rf) begin
      c = 8'(({2'b00, edg.left} + {1'b0, edg.right}) >> 1);
    end else if (gap) begin
      cross_nxt = cross_r + 1'b1;
    end else if (!edg.lf && edg.rf && cross_r == '0) begin
      c = {1'b0, edg.right} - ({1'b0, prev_right_r} - prev_center_r);
      lturn_nxt = 1'b1;
    end else if (edg.lf && !edg.rf && cross_r == '0) begin
      c = {2'b00, edg.left} + (prev_center_r - {1'b0, prev_left_r});
      rturn_nxt = 1'b1;
    end
    st_nxt.last = last;
    st_nxt.ca   = (rc_r == lets_pkg::RC_W'(lets_pkg::RC_A)) ? c : ca_r;
    st_nxt.cb   = (rc_r == lets_pkg::RC_W'(lets_pkg::RC_B)) ? c : cb_r;
    st_nxt.gain = {1'b0, duty_gain_r} +
                  ((lturn_nxt && rturn_nxt) ? lets_pkg::GSUM_W'(lets_pkg::TURN_BONUS) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r          <= '0;
      prev_left_r   <= lets_pkg::RIGHT_W'(lets_pkg::LEFT_DEF);
      prev_right_r  <= lets_pkg::RIGHT_W'(lets_pkg::RIGHT_DEF);
      prev_center_r <= lets_pkg::CENTER_W'(lets_pkg::CENTER_DEF);
      cross_r       <= '0;
      lturn_r       <= 1'b0;
      rturn_r       <= 1'b0;
      row_valid_r   <= '0;
      ca_r          <= '0;
      cb_r          <= '0;
    end else if (accept) begin
      rc_r <= rc_nxt;
      row_valid_r[rc_r[lets_pkg::ROW_AW-1:0]] <= 1'b1;
      ca_r <= st_nxt.ca;
      cb_r <= st_nxt.cb;
      if (last) begin
        prev_left_r   <= lets_pkg::RIGHT_W'(lets_pkg::LEFT_DEF);
        prev_right_r  <= lets_pkg::RIGHT_W'(lets_pkg::RIGHT_DEF);
        prev_center_r <= lets_pkg::CENTER_W'(lets_pkg::CENTER_DEF);
        cross_r       <= '0;
        lturn_r       <= 1'b0;
        rturn_r       <= 1'b0;
      end else begin
        prev_left_r   <= {1'b0, edg.left};
        prev_right_r  <= edg.right;
        prev_center_r <= c;
        cross_r       <= cross_nxt;
        lturn_r       <= lturn_nxt;
        rturn_r       <= rturn_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_left_r      <= edg.left;
      s1_right_r     <= edg.right;
      s1_c_r         <= c;
      s1_st_r        <= st_nxt;
      s2_left_r      <= s1_left_r;
      s2_right_r     <= s1_right_r;
      s2_c_r         <= s1_c_r;
      s2_last_r      <= s1_st_r.last;
      out_left_edge  <= s2_left_r;
      out_right_edge <= s2_right_r;
      out_center_col <= s2_c_r;
      out_frame_done <= s2_last_r;
    end
  end

  assign dcfg.center = duty_center_r;
  assign dcfg.dmin   = duty_min_r;
  assign dcfg.dmax   = duty_max_r;

  lets_steer u_steer (
    .clk     (clk),
    .advance (advance),
    .st      (s1_st_r),
    .cfg     (dcfg),
    .duty    (out_steer_duty)
  );

  `LETS_ASSERT_IMP(a_rc_bound, 1'b1, rc_r < lets_pkg::RC_W'(lets_pkg::SCAN_ROWS), "row count out of range")
  `LETS_ASSERT_NXT(a_frame_wrap, accept && last, rc_r == '0, "row count did not wrap at frame end")
  `LETS_ASSERT_NXT(a_rc_step, accept && !last, rc_r == $past(rc_r) + 1'b1, "row count did not advance")
  `LETS_ASSERT_IMP(a_duty_idle, out_valid && !out_frame_done, out_steer_duty == '0, "duty set on non-final row")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Lane edge tracker testbench
// Sends camera rows through the row channel with random gaps and output
// stalls. A local row tracker predicts edges, centers and steering duty for
// each transaction, and every output row is checked in order against it
// across a series of duty register settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT        = 3;
  localparam int HOLD_CYCLES     = 150;
  localparam int WATCH_LIMIT     = 4000;
  localparam int IDLE_PCT        = 32;
  localparam int REPORT_MAX      = 10;
  localparam int CFG_SLOTS       = 1 << lets_pkg::CFG_IW;
  localparam int RST_DUTY_CENTER = 5000;
  localparam int RST_DUTY_GAIN   = 10;
  localparam int RST_DUTY_MIN    = 4000;
  localparam int RST_DUTY_MAX    = 6000;

  typedef logic [lets_pkg::IMG_COLS-1:0] row_t;

  typedef struct packed {
    logic [lets_pkg::LEFT_W-1:0]   left_edge;
    logic [lets_pkg::RIGHT_W-1:0]  right_edge;
    logic [lets_pkg::CENTER_W-1:0] center_col;
    logic                          frame_done;
    logic [lets_pkg::DUTY_W-1:0]   steer_duty;
  } row_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [lets_pkg::HALF_COLS-1:0] in_pixels_low;
  logic [lets_pkg::HALF_COLS-1:0] in_pixels_high;
  logic                           out_valid;
  logic                           out_ready;
  logic [lets_pkg::LEFT_W-1:0]    out_left_edge;
  logic [lets_pkg::RIGHT_W-1:0]   out_right_edge;
  logic [lets_pkg::CENTER_W-1:0]  out_center_col;
  logic                           out_frame_done;
  logic [lets_pkg::DUTY_W-1:0]    out_steer_duty;
  logic                           cfg_we;
  logic [lets_pkg::CFG_IW-1:0]    cfg_index;
  logic [lets_pkg::DUTY_W-1:0]    cfg_wdata;

  // row tracker state
  logic [lets_pkg::CENTER_W-1:0] center_mem [lets_pkg::IMG_ROWS];
  int row_pos, last_left, last_right, last_center, crossings;
  bit left_turn, right_turn;
  int duty_mid, duty_slope, duty_lo, duty_hi;

  row_result_t expected_rows[$];

  int mismatches = 0;
  int rows_sent = 0;
  int rows_checked = 0;
  int frames_seen = 0;
  int turn_frames = 0;
  int cross_rows = 0;
  int clamp_hits = 0;
  int settings_used = 1;
  int quiet_cycles = 0;
  int send_idle_pct = IDLE_PCT;
  int recv_idle_pct = IDLE_PCT;
  bit hold_request = 1'b0;
  bit clean_frame = 1'b0;

  lane_edge_tracker_steering u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixels_low  (in_pixels_low),
    .in_pixels_high (in_pixels_high),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left_edge  (out_left_edge),
    .out_right_edge (out_right_edge),
    .out_center_col (out_center_col),
    .out_frame_done (out_frame_done),
    .out_steer_duty (out_steer_duty),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void restart_frame();
    row_pos     = 0;
    last_left   = lets_pkg::LEFT_DEF;
    last_right  = lets_pkg::RIGHT_DEF;
    last_center = lets_pkg::CENTER_DEF;
    crossings   = 0;
    left_turn   = 1'b0;
    right_turn  = 1'b0;
  endfunction

  function automatic row_t span(int lo_col, int hi_col);
    row_t row;
    row = '0;
    for (int c = lo_col; c <= hi_col; c++) row[c] = 1'b1;
    return row;
  endfunction

  function automatic row_result_t track_row(row_t row);
    row_result_t res;
    int left, right, c, y, t, g, d;
    bit lf, rf;
    left  = lets_pkg::LEFT_DEF;
    right = lets_pkg::RIGHT_DEF;
    lf    = 1'b0;
    rf    = 1'b0;
    for (int x = lets_pkg::SCAN_ORIGIN; x >= 2; x--) begin
      if (!lf && row[x] && !row[x-2]) begin
        left = x + 2;
        lf   = 1'b1;
      end
    end
    for (int x = lets_pkg::SCAN_ORIGIN; x <= lets_pkg::IMG_COLS - 3; x++) begin
      if (!rf && row[x] && !row[x+2]) begin
        right = x - 2;
        rf    = 1'b1;
      end
    end
    y = lets_pkg::IMG_ROWS - 1 - row_pos % lets_pkg::SCAN_ROWS;
    c = int'(center_mem[y]);
    if (lf && rf) begin
      c = (left + right) / 2;
    end else if (right - left > lets_pkg::CROSS_GAP) begin
      crossings = (crossings + 1) % (1 << lets_pkg::CROSS_W);
      cross_rows++;
    end else if (!lf && rf && crossings == 0) begin
      c = (right - (last_right - last_center)) & 'hFF;
      left_turn = 1'b1;
    end else if (lf && !rf && crossings == 0) begin
      c = (left + (last_center - last_left)) & 'hFF;
      right_turn = 1'b1;
    end
    center_mem[y] = lets_pkg::CENTER_W'(c);
    last_left     = left;
    last_right    = right;
    last_center   = c;
    res            = '0;
    res.left_edge  = lets_pkg::LEFT_W'(left);
    res.right_edge = lets_pkg::RIGHT_W'(right);
    res.center_col = lets_pkg::CENTER_W'(c);
    if (row_pos + 1 >= lets_pkg::SCAN_ROWS) begin
      t = (8 * (int'(center_mem[lets_pkg::ROW_A]) - lets_pkg::CENTER_DEF)
         + 2 * (int'(center_mem[lets_pkg::ROW_B]) - lets_pkg::CENTER_DEF)) / 10;
      g = duty_slope + ((left_turn && right_turn) ? lets_pkg::TURN_BONUS : 0);
      d = duty_mid + t * g;
      if (d <= duty_lo) d = duty_lo;
      if (d >= duty_hi) d = duty_hi;
      if (d == duty_lo || d == duty_hi) clamp_hits++;
      if (left_turn && right_turn) turn_frames++;
      frames_seen++;
      res.frame_done = 1'b1;
      res.steer_duty = lets_pkg::DUTY_W'(d);
      restart_frame();
    end else begin
      row_pos++;
    end
    return res;
  endfunction

  task automatic push_row(row_t row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixels_low  <= row[lets_pkg::HALF_COLS-1:0];
    in_pixels_high <= row[lets_pkg::IMG_COLS-1:lets_pkg::HALF_COLS];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rows.push_back(track_row(row));
    rows_sent++;
    @(negedge clk);
  endtask

  task automatic run_lane_rows(int count);
    row_t row;
    int kind, pick;
    repeat (count) begin
      if (row_pos == 0) clean_frame = 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 99);
      if (kind < 8 && !clean_frame)
        row = {lets_pkg::IMG_COLS{1'($urandom_range(0, 1))}};
      else if (kind < 22)
        row = row_t'({$urandom, $urandom, $urandom});
      else if (kind < 34)
        row = span(0, $urandom_range(lets_pkg::HALF_COLS,
                                     clean_frame ? 62 : lets_pkg::IMG_COLS - 1));
      else if (kind < 46)
        row = span($urandom_range(clean_frame ? 17 : 0, lets_pkg::HALF_COLS),
                   lets_pkg::IMG_COLS - 1);
      else
        row = span($urandom_range(0, 44), $urandom_range(36, lets_pkg::IMG_COLS - 1));
      if (kind >= 22 && $urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, lets_pkg::IMG_COLS - 1);
        row[pick] = ~row[pick];
      end
      push_row(row);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 2) @(negedge clk);
  endtask

  task automatic write_reg(logic [lets_pkg::CFG_IW-1:0] idx,
                           logic [lets_pkg::DUTY_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      lets_pkg::REG_DUTY_CENTER: duty_mid = int'(value);
      lets_pkg::REG_DUTY_GAIN:   duty_slope = int'(value[lets_pkg::GAIN_W-1:0]);
      lets_pkg::REG_DUTY_MIN:    duty_lo = int'(value);
      lets_pkg::REG_DUTY_MAX:    duty_hi = int'(value);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(int mid, int slope, int lo, int hi);
    wait_idle();
    write_reg(lets_pkg::REG_DUTY_CENTER, lets_pkg::DUTY_W'(mid));
    write_reg(lets_pkg::REG_DUTY_GAIN, lets_pkg::DUTY_W'(slope));
    write_reg(lets_pkg::REG_DUTY_MIN, lets_pkg::DUTY_W'(lo));
    write_reg(lets_pkg::REG_DUTY_MAX, lets_pkg::DUTY_W'(hi));
    // unmapped slots must be ignored
    for (int idx = int'(lets_pkg::REG_DUTY_MAX) + 1; idx < CFG_SLOTS; idx++)
      write_reg(lets_pkg::CFG_IW'(idx), lets_pkg::DUTY_W'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic test_turn_and_crossing();
    push_row(span(0, 50));
    push_row(span(30, lets_pkg::IMG_COLS - 1));
    push_row(span(10, lets_pkg::IMG_COLS - 1));
    push_row(span(0, 70));
    push_row(span(0, 50));
    push_row(span(30, lets_pkg::IMG_COLS - 1));
  endtask

  task automatic test_edge_scan();
    push_row('0);
    push_row('1);
    push_row(span(lets_pkg::HALF_COLS, lets_pkg::HALF_COLS));
    push_row(span(1, lets_pkg::IMG_COLS - 2));
    push_row(span(0, lets_pkg::HALF_COLS - 1));
    push_row(span(lets_pkg::HALF_COLS, lets_pkg::IMG_COLS - 1));
    push_row({lets_pkg::IMG_COLS/2{2'b01}});
    push_row({lets_pkg::IMG_COLS/2{2'b10}});
    push_row(span(20, 60));
    repeat (6) push_row(row_t'({$urandom, $urandom, $urandom}));
  endtask

  task automatic test_random_frames();
    run_lane_rows(120);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_lane_rows(120);
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
  endtask

  task automatic test_config_sweep();
    apply_setting(0, 0, 0, 0);
    run_lane_rows(100);
    apply_setting(10000, 255, 0, 10000);
    run_lane_rows(100);
    apply_setting(16383, 16383, 0, 16383);
    run_lane_rows(100);
    apply_setting(5000, 300, 6000, 4000);
    run_lane_rows(100);
    apply_setting(0, 200, 0, 10000);
    run_lane_rows(100);
    apply_setting(5000, 30, 4800, 5200);
    run_lane_rows(100);
    repeat (2) begin
      apply_setting($urandom_range(0, 10000), $urandom_range(0, 255),
                    $urandom_range(0, 10000), $urandom_range(0, 10000));
      run_lane_rows(100);
    end
    apply_setting(RST_DUTY_CENTER, RST_DUTY_GAIN, RST_DUTY_MIN, RST_DUTY_MAX);
    run_lane_rows(100);
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    hold_request  = 1'b1;
    run_lane_rows(60);
    send_idle_pct = IDLE_PCT;
  endtask

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : row_checker
    row_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_left_edge, out_right_edge, out_center_col, out_frame_done, out_steer_duty};
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: output row with nothing pending: %h", $realtime, got);
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: row %0d expected L%0d R%0d C%0d done %0b duty %0d, ",
                     $realtime, rows_checked, want.left_edge, want.right_edge,
                     want.center_col, want.frame_done, want.steer_duty,
                     "got L%0d R%0d C%0d done %0b duty %0d",
                     got.left_edge, got.right_edge, got.center_col,
                     got.frame_done, got.steer_duty);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", WATCH_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixels_low  = '0;
    in_pixels_high = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    foreach (center_mem[i]) center_mem[i] = '0;
    restart_frame();
    duty_mid   = RST_DUTY_CENTER;
    duty_slope = RST_DUTY_GAIN;
    duty_lo    = RST_DUTY_MIN;
    duty_hi    = RST_DUTY_MAX;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_turn_and_crossing();
    test_edge_scan();
    test_random_frames();
    test_config_sweep();
    test_output_backpressure();
    wait_idle();

    $display("Checked %0d of %0d rows over %0d frames and %0d duty settings",
             rows_checked, rows_sent, frames_seen, settings_used);
    $display("Crossing rows %0d, frames with both turns %0d, clamped duties %0d, failures %0d",
             cross_rows, turn_frames, clamp_hits, mismatches);
    if (mismatches == 0 && expected_rows.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
